// ===== hdl/csa_pkg.sv =====
// Package for the CSR scatter-add block: field widths, matrix sizes,
// function and status codes, word and memory-request types.
// No dependencies; every other file of the block but csa_ram imports it.
package csa_pkg;

  // Matrix sizes
  localparam int unsigned ROWS     = 1024;
  localparam int unsigned NNZ      = 8192;
  localparam int unsigned RS_DEPTH = ROWS + 1;
  localparam int unsigned RS_AW    = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;
  localparam int unsigned ENT_AW   = (NNZ > 1) ? $clog2(NNZ) : 1;

  // Field widths
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned ROW_W  = 11;
  localparam int unsigned COL_W  = 10;
  localparam int unsigned POS_W  = 14;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FPOS_W = 13;

  typedef enum logic [FUNC_W-1:0] {
    FN_WR_ROW = 3'd0,
    FN_WR_COL = 3'd1,
    FN_WR_VAL = 3'd2,
    FN_ACC    = 3'd3,
    FN_RD_VAL = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    last_entry;
  } in_word_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [FPOS_W-1:0]       found_position;
    logic                    last_out;
  } out_word_t;

  // Row-start table port
  typedef struct packed {
    logic             we;
    logic [RS_AW-1:0] waddr;
    logic [POS_W-1:0] wdata;
    logic             re;
    logic [RS_AW-1:0] raddr;
  } rs_req_t;

  // Column-index and value memories share one address scheme
  typedef struct packed {
    logic              col_we;
    logic              val_we;
    logic [ENT_AW-1:0] waddr;
    logic [COL_W-1:0]  col_wdata;
    logic [VAL_W-1:0]  val_wdata;
    logic              re;
    logic [ENT_AW-1:0] raddr;
  } ent_req_t;

endpackage

// ===== hdl/csa_if.sv =====
// Valid/ready channel interfaces for the input and result words.
// Depends on csa_pkg for the word types.
interface csa_in_if;
  import csa_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csa_out_if;
  import csa_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/csa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency; contents are undefined until written.
module csa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8192
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/csa_ctrl.sv =====
// Sequencer of the CSR scatter-add block: decodes each word, drives the
// memories, scans a row with one shared adder and holds the result word.
// Depends on csa_pkg and csa_if.
module csa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  csa_in_if.sink             in_i,
  csa_out_if.source          out_o,
  output csa_pkg::rs_req_t   rs_req_o,
  input  logic [csa_pkg::POS_W-1:0] rs_rdata_i,
  output csa_pkg::ent_req_t  ent_req_o,
  input  logic [csa_pkg::COL_W-1:0] col_rdata_i,
  input  logic [csa_pkg::VAL_W-1:0] val_rdata_i
);
  import csa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_EXEC     = 8'b0000_0010,
    S_RS_HI    = 8'b0000_0100,
    S_RS_WAIT  = 8'b0000_1000,
    S_SCAN     = 8'b0001_0000,
    S_CMP      = 8'b0010_0000,
    S_ENT_WAIT = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_e;

  state_e            st_q, st_d;
  in_word_t          item_q, item_d;
  logic [POS_W-1:0]  at_q, at_d;
  logic [POS_W-1:0]  bound_q, bound_d;
  status_e           res_st_q, res_st_d;
  logic [VAL_W-1:0]  res_val_q, res_val_d;
  logic [FPOS_W-1:0] res_pos_q, res_pos_d;
  out_word_t         out_q, out_d;
  logic              out_vld_q, out_vld_d;

  // Shared adder: saturating accumulate or scan-pointer increment
  logic [VAL_W:0]    alu_a, alu_b, alu_sum;
  logic [VAL_W-1:0]  sat_sum;
  logic              col_hit;
  logic              ent_in_range;
  logic [RS_AW-1:0]  row_idx, row_idx_hi;
  logic [ENT_AW-1:0] pos_idx, at_idx;

  assign col_hit      = (col_rdata_i == item_q.col);
  assign ent_in_range = (32'(item_q.position) < NNZ);
  assign row_idx      = RS_AW'(item_q.row);
  assign row_idx_hi   = RS_AW'(32'(item_q.row) + 32'd1);
  assign pos_idx      = ENT_AW'(item_q.position);
  assign at_idx       = ENT_AW'(at_q);

  always_comb begin
    if (col_hit) begin
      alu_a = {val_rdata_i[VAL_W-1], val_rdata_i};
      alu_b = {item_q.value[VAL_W-1], item_q.value};
    end else begin
      alu_a = (VAL_W + 1)'(at_q);
      alu_b = (VAL_W + 1)'(1);
    end
    alu_sum = alu_a + alu_b;
    // Clamp on signed overflow
    if (alu_sum[VAL_W] != alu_sum[VAL_W-1]) begin
      sat_sum = alu_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      sat_sum = alu_sum[VAL_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    st_d      = st_q;
    item_d    = item_q;
    at_d      = at_q;
    bound_d   = bound_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    res_pos_d = res_pos_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    rs_req_o  = '0;
    ent_req_o = '0;
    in_i.ready = 1'b0;

    // Drop the result word once taken
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          item_d = in_i.data;
          st_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        res_st_d  = ST_RANGE;
        res_val_d = '0;
        res_pos_d = '0;
        st_d      = S_FIN;
        case (item_q.func)
          FN_WR_ROW: begin
            if (32'(item_q.row) <= ROWS) begin
              rs_req_o.we    = 1'b1;
              rs_req_o.waddr = row_idx;
              rs_req_o.wdata = item_q.position;
              res_st_d       = ST_OK;
            end
          end
          FN_WR_COL, FN_WR_VAL, FN_RD_VAL: begin
            if (ent_in_range) begin
              ent_req_o.col_we    = (item_q.func == FN_WR_COL);
              ent_req_o.val_we    = (item_q.func == FN_WR_VAL);
              ent_req_o.waddr     = pos_idx;
              ent_req_o.col_wdata = item_q.col;
              ent_req_o.val_wdata = item_q.value;
              ent_req_o.re        = 1'b1;
              ent_req_o.raddr     = pos_idx;
              st_d                = S_ENT_WAIT;
            end
          end
          FN_ACC: begin
            if (32'(item_q.row) < ROWS) begin
              rs_req_o.re    = 1'b1;
              rs_req_o.raddr = row_idx;
              st_d           = S_RS_HI;
            end
          end
          default: begin
            res_st_d = ST_RANGE;
          end
        endcase
      end
      S_RS_HI: begin
        rs_req_o.re    = 1'b1;
        rs_req_o.raddr = row_idx_hi;
        at_d           = rs_rdata_i;
        st_d           = S_RS_WAIT;
      end
      S_RS_WAIT: begin
        // Stop the scan at the end of the entry memory
        if (32'(rs_rdata_i) > NNZ) begin
          bound_d = POS_W'(NNZ);
        end else begin
          bound_d = rs_rdata_i;
        end
        st_d = S_SCAN;
      end
      S_SCAN: begin
        if (at_q < bound_q) begin
          ent_req_o.re    = 1'b1;
          ent_req_o.raddr = at_idx;
          st_d            = S_CMP;
        end else begin
          res_st_d = ST_NOT_FOUND;
          st_d     = S_FIN;
        end
      end
      S_CMP: begin
        if (col_hit) begin
          ent_req_o.val_we    = 1'b1;
          ent_req_o.waddr     = at_idx;
          ent_req_o.val_wdata = sat_sum;
          res_st_d            = ST_OK;
          res_val_d           = sat_sum;
          res_pos_d           = FPOS_W'(at_q);
          st_d                = S_FIN;
        end else begin
          at_d = alu_sum[POS_W-1:0];
          st_d = S_SCAN;
        end
      end
      S_ENT_WAIT: begin
        res_st_d  = ST_OK;
        res_val_d = (item_q.func == FN_WR_VAL) ? item_q.value : val_rdata_i;
        res_pos_d = FPOS_W'(item_q.position);
        st_d      = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free
        if (!out_vld_q || out_o.ready) begin
          out_d.status         = res_st_q;
          out_d.read_value     = res_val_q;
          out_d.found_position = res_pos_q;
          out_d.last_out       = item_q.last_entry;
          out_vld_d            = 1'b1;
          st_d                 = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    at_q      <= at_d;
    bound_q   <= bound_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    res_pos_q <= res_pos_d;
    out_q     <= out_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule

// ===== hdl/csr_scatter_add.sv =====
// Steps, accept to result word: row-start writes and range errors decode and finish;
//   entry writes and reads also wait for the registered read; accumulate reads both
//   row starts, then compares entries in turn, each after a column-index read.
// Throughput: one word at a time; the next is taken in the cycle after the result loads.
// Reset: asynchronous, active low; clears the sequencer and the result valid.
//   Memories are not cleared and hold undefined data until written.
module csr_scatter_add (
  input  logic      clk_i,
  input  logic      rst_ni,
  csa_in_if.sink    in_i,
  csa_out_if.source out_o
);
  import csa_pkg::*;

  rs_req_t          rs_req;
  ent_req_t         ent_req;
  logic [POS_W-1:0] rs_rdata;
  logic [COL_W-1:0] col_rdata;
  logic [VAL_W-1:0] val_rdata;

  // Row-start table
  csa_ram #(.Width(POS_W), .Depth(RS_DEPTH)) u_rs_ram (
    .clk_i   (clk_i),
    .we_i    (rs_req.we),
    .waddr_i (rs_req.waddr),
    .wdata_i (rs_req.wdata),
    .re_i    (rs_req.re),
    .raddr_i (rs_req.raddr),
    .rdata_o (rs_rdata)
  );

  // Column indices
  csa_ram #(.Width(COL_W), .Depth(NNZ)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ent_req.col_we),
    .waddr_i (ent_req.waddr),
    .wdata_i (ent_req.col_wdata),
    .re_i    (ent_req.re),
    .raddr_i (ent_req.raddr),
    .rdata_o (col_rdata)
  );

  // Entry values
  csa_ram #(.Width(VAL_W), .Depth(NNZ)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (ent_req.val_we),
    .waddr_i (ent_req.waddr),
    .wdata_i (ent_req.val_wdata),
    .re_i    (ent_req.re),
    .raddr_i (ent_req.raddr),
    .rdata_o (val_rdata)
  );

  csa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .rs_req_o   (rs_req),
    .rs_rdata_i (rs_rdata),
    .ent_req_o  (ent_req),
    .col_rdata_i(col_rdata),
    .val_rdata_i(val_rdata)
  );

endmodule

// ===== hdl/csa_checker.sv =====
// Port-level checks for csr_scatter_add, attached by bind.
// Depends on csa_pkg for the result word type.
module csa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input csa_pkg::out_word_t out_data_i
);
  import csa_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word dropped or changed while stalled");

  // One word in flight: ready drops after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a word is in flight");

  // Failed operations report zero value and address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status != ST_OK) |->
      (out_data_i.read_value == '0) && (out_data_i.found_position == '0))
    else $error("failed operation reports nonzero data");

endmodule

bind csr_scatter_add csa_checker u_csa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ===== test/csr_scatter_add_tb.sv =====
`timescale 1ns / 1ps
// Testbench for csr_scatter_add: loads sparse-row layouts, scatters values into them and
// checks every result word against an internal copy of the matrix store, in order.
// Depends on csa_pkg, the channel interfaces in csa_if and the csr_scatter_add RTL.
module csr_scatter_add_tb;
  import csa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned STALL_HOLD     = 300;
  localparam int unsigned ITEM_TARGET    = 950;
  localparam int unsigned ROW_SPAN       = 1 << ROW_W;
  localparam int unsigned POS_SPAN       = 1 << POS_W;
  localparam logic [FUNC_W-1:0] FN_BAD   = 3'd7;
  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

  logic clk_i;
  logic rst_ni;

  csa_in_if  in_ch ();
  csa_out_if out_ch ();

  csr_scatter_add DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Shadow copy of the matrix store, with a written flag per entry
  logic [POS_W-1:0]        row_start_m   [RS_DEPTH];
  bit                      row_start_set [RS_DEPTH];
  logic [COL_W-1:0]        col_m         [NNZ];
  bit                      col_set       [NNZ];
  logic signed [VAL_W-1:0] val_m         [NNZ];
  bit                      val_set       [NNZ];

  // Result words owed by the block, oldest first
  out_word_t owed_q [$];
  int        pending;

  int unsigned n_sent, n_ignored, n_checked, n_errors;
  int unsigned n_hits, n_misses, n_saturated, n_range;

  // Idle control for both sides
  bit          tx_steady;
  bit          rx_steady;
  int unsigned rx_hold;

  // Layout of the most recently loaded block of rows
  int unsigned blk_row0, blk_rows, blk_base, blk_end;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Compute the result of one word and apply it to the shadow store
  function automatic out_word_t csr_apply(in_word_t w);
    out_word_t r;
    int unsigned at, bound;
    logic signed [VAL_W:0] sum;
    logic [ENT_AW-1:0] ea;
    r = '0;
    r.status = ST_OK;
    r.last_out = w.last_entry;
    case (w.func)
      FN_WR_ROW: begin
        if (32'(w.row) <= ROWS) begin
          row_start_m[w.row] = w.position;
          row_start_set[w.row] = 1'b1;
        end else begin
          r.status = ST_RANGE;
        end
      end
      FN_WR_COL, FN_WR_VAL, FN_RD_VAL: begin
        if (32'(w.position) < NNZ) begin
          ea = ENT_AW'(w.position);
          if (w.func == FN_WR_COL) begin
            col_m[ea] = w.col;
            col_set[ea] = 1'b1;
          end else if (w.func == FN_WR_VAL) begin
            val_m[ea] = w.value;
            val_set[ea] = 1'b1;
          end
          r.read_value = val_m[ea];
          r.found_position = FPOS_W'(ea);
        end else begin
          r.status = ST_RANGE;
        end
      end
      FN_ACC: begin
        if (32'(w.row) < ROWS) begin
          at = 32'(row_start_m[w.row]);
          bound = 32'(row_start_m[RS_AW'(32'(w.row) + 32'd1)]);
          if (bound > NNZ) bound = NNZ;
          r.status = ST_NOT_FOUND;
          // scan the row; stop at the first matching column
          while (at < bound && r.status == ST_NOT_FOUND) begin
            ea = ENT_AW'(at);
            if (col_m[ea] == w.col) begin
              sum = {val_m[ea][VAL_W-1], val_m[ea]} + {w.value[VAL_W-1], w.value};
              if (sum[VAL_W] != sum[VAL_W-1]) begin
                val_m[ea] = sum[VAL_W] ? Q_MIN : Q_MAX;
                n_saturated++;
              end else begin
                val_m[ea] = sum[VAL_W-1:0];
              end
              r.status = ST_OK;
              r.read_value = val_m[ea];
              r.found_position = FPOS_W'(at);
            end else begin
              at++;
            end
          end
          if (r.status == ST_OK) n_hits++;
          else n_misses++;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    if (r.status == ST_RANGE) n_range++;
    return r;
  endfunction

  // True when the word touches no store entry that was never written
  function automatic bit word_is_safe(in_word_t w);
    int unsigned at, bound;
    logic [RS_AW-1:0] hi;
    case (w.func)
      FN_WR_COL, FN_RD_VAL: begin
        return (32'(w.position) >= NNZ) || val_set[ENT_AW'(w.position)];
      end
      FN_ACC: begin
        if (32'(w.row) >= ROWS) return 1'b1;
        hi = RS_AW'(32'(w.row) + 32'd1);
        if (!row_start_set[w.row] || !row_start_set[hi]) return 1'b0;
        at = 32'(row_start_m[w.row]);
        bound = 32'(row_start_m[hi]);
        if (bound > NNZ) bound = NNZ;
        while (at < bound) begin
          if (!col_set[ENT_AW'(at)]) return 1'b0;
          if (col_m[ENT_AW'(at)] == w.col) return val_set[ENT_AW'(at)];
          at++;
        end
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return $urandom_range(0, 'h3FFFF);
      3: return ~$urandom_range(0, 'h3FFFF);
      4: return {4'b0111, 28'($urandom)};
      5: return {4'b1000, 28'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Fill every field at random; callers override the ones that matter
  function automatic in_word_t noise_word();
    in_word_t w;
    w.func       = FUNC_W'($urandom_range(0, FN_BAD));
    w.row        = ROW_W'($urandom_range(0, ROW_SPAN - 1));
    w.col        = COL_W'($urandom_range(0, (1 << COL_W) - 1));
    w.position   = POS_W'($urandom_range(0, POS_SPAN - 1));
    w.value      = $urandom;
    w.last_entry = 1'($urandom_range(0, 1));
    return w;
  endfunction

  function automatic in_word_t make_word(logic [FUNC_W-1:0] f, int unsigned row,
                                         int unsigned col, int unsigned pos,
                                         logic [VAL_W-1:0] v);
    in_word_t w;
    w.func       = f;
    w.row        = row[ROW_W-1:0];
    w.col        = col[COL_W-1:0];
    w.position   = pos[POS_W-1:0];
    w.value      = v;
    w.last_entry = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // A written entry address, inside the current block when it has any
  function automatic int unsigned blk_pos();
    if (blk_end > blk_base) return $urandom_range(blk_base, blk_end - 1);
    return $urandom_range(0, 2);
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Offer one word after a random gap; record its result once accepted
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    owed_q.push_back(csr_apply(w));
    pending++;
    n_sent++;
    if (w.func > FN_RD_VAL) n_ignored++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait for every owed result word
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    n_checked++;
    if (owed_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing outstanding", n_checked));
      return;
    end
    want = owed_q.pop_front();
    pending--;
    if (got.status !== want.status)
      report_mismatch($sformatf("result %0d status %0d, want %0d",
                                n_checked, got.status, want.status));
    if (got.read_value !== want.read_value)
      report_mismatch($sformatf("result %0d read_value %h, want %h",
                                n_checked, got.read_value, want.read_value));
    if (got.found_position !== want.found_position)
      report_mismatch($sformatf("result %0d found_position %0d, want %0d",
                                n_checked, got.found_position, want.found_position));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("result %0d last_out %b, want %b",
                                n_checked, got.last_out, want.last_out));
  endtask

  // Accept result words with random stalls, or one long hold on request
  initial begin : result_sink
    out_word_t   got;
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      got = out_ch.data;
      check_result(got);
      @(negedge clk_i);
    end
  end

  // End the run when no word moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("csr_scatter_add_tb: errors");
    $finish;
  end

  // Row 0 with a repeated column; accumulate to both clamp limits and miss once
  task automatic test_store_and_saturate();
    send_word(make_word(FN_WR_ROW, 0, 0, 0, 0));
    send_word(make_word(FN_WR_ROW, 1, 0, 3, 0));
    send_word(make_word(FN_WR_VAL, 0, 0, 0, 32'h7FFF_FFF0));
    send_word(make_word(FN_WR_VAL, 0, 0, 1, 32'h8000_0010));
    send_word(make_word(FN_WR_VAL, 0, 0, 2, 32'h0001_8000));
    send_word(make_word(FN_WR_COL, 0, 5, 0, 0));
    send_word(make_word(FN_WR_COL, 0, 1023, 1, 0));
    // same column again: the first entry must take the sum
    send_word(make_word(FN_WR_COL, 0, 5, 2, 0));
    send_word(make_word(FN_ACC, 0, 5, 0, 32'h0000_0100));
    send_word(make_word(FN_ACC, 0, 1023, 0, 32'hFFFF_FF00));
    send_word(make_word(FN_ACC, 0, 7, 0, 32'h0001_0000));
    send_word(make_word(FN_RD_VAL, 0, 0, 2, 0));
  endtask

  // Row end past the store clamps at the last entry; an inverted row finds nothing
  task automatic test_row_bounds();
    send_word(make_word(FN_WR_ROW, ROWS - 1, 0, NNZ - 2, 0));
    send_word(make_word(FN_WR_ROW, ROWS, 0, POS_SPAN - 1, 0));
    send_word(make_word(FN_WR_VAL, 0, 0, NNZ - 2, 32'h0000_0001));
    send_word(make_word(FN_WR_VAL, 0, 0, NNZ - 1, 32'hFFFF_FFFF));
    send_word(make_word(FN_WR_COL, 0, 3, NNZ - 2, 0));
    send_word(make_word(FN_WR_COL, 0, 1023, NNZ - 1, 0));
    send_word(make_word(FN_ACC, ROWS - 1, 1023, 0, 32'h7FFF_FFFF));
    send_word(make_word(FN_WR_ROW, 2, 0, 1, 0));
    send_word(make_word(FN_ACC, 1, 5, 0, 32'h0000_0001));
  endtask

  // Addresses and rows past the store, and an unknown function
  task automatic test_range_errors();
    send_word(make_word(FN_WR_VAL, 0, 0, NNZ, 32'hDEAD_BEEF));
    send_word(make_word(FN_RD_VAL, 0, 0, POS_SPAN - 1, 0));
    send_word(make_word(FN_WR_COL, ROW_SPAN - 1, 1023, NNZ + 1, 32'hFFFF_FFFF));
    send_word(make_word(FN_WR_ROW, ROW_SPAN - 1, 0, 5, 0));
    send_word(make_word(FN_ACC, ROWS, 5, 0, 32'h0000_0001));
    send_word(make_word(FN_BAD, ROW_SPAN - 1, 1023, POS_SPAN - 1, 32'hFFFF_FFFF));
  endtask

  // Hold the result side for a long stretch while words keep coming
  task automatic test_stall_pressure();
    int unsigned k;
    drain();
    tx_steady = 1'b1;
    rx_hold = STALL_HOLD;
    for (k = 0; k < 12; k++) begin
      if (k[0]) send_word(make_word(FN_RD_VAL, 0, 0, $urandom_range(0, 2), 0));
      else send_word(make_word(FN_ACC, 0, k[1] ? 5 : 1023, 0, pick_value()));
    end
    tx_steady = 1'b0;
    drain();
  endtask

  // Load a block of rows at random rows and addresses; columns repeat now and then
  task automatic build_block(input int unsigned nrows);
    in_word_t    w;
    int unsigned pos, n, c, r, k;
    blk_rows = nrows;
    blk_row0 = $urandom_range(0, ROWS - nrows);
    blk_base = $urandom_range(0, NNZ - nrows * 16);
    pos = blk_base;
    for (r = 0; r <= nrows; r++) begin
      w = noise_word();
      w.func = FN_WR_ROW;
      w.row = ROW_W'(blk_row0 + r);
      w.position = POS_W'(pos);
      send_word(w);
      if (r < nrows) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 5);
        c = 0;
        for (k = 0; k < n; k++) begin
          if (k == 0 || $urandom_range(0, 2) != 0) c = $urandom_range(0, (1 << COL_W) - 1);
          w = noise_word();
          w.func = FN_WR_VAL;
          w.position = POS_W'(pos);
          w.value = pick_value();
          send_word(w);
          w = noise_word();
          w.func = FN_WR_COL;
          w.position = POS_W'(pos);
          w.col = COL_W'(c);
          send_word(w);
          pos++;
        end
      end
    end
    blk_end = pos;
  endtask

  // Mostly accumulates into the loaded block, with reads, rewrites and bad words mixed in
  function automatic in_word_t traffic_word();
    in_word_t    w;
    int unsigned row, at, bound, sel;
    w = noise_word();
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      w.func = FN_ACC;
      row = blk_row0 + $urandom_range(0, blk_rows - 1);
      w.row = ROW_W'(row);
      at = 32'(row_start_m[RS_AW'(row)]);
      bound = 32'(row_start_m[RS_AW'(row + 1)]);
      if (at < bound && $urandom_range(0, 5) != 0)
        w.col = col_m[ENT_AW'($urandom_range(at, bound - 1))];
      w.value = pick_value();
    end else if (sel < 62) begin
      w.func = FN_ACC;
      w.row = ROW_W'($urandom_range(0, ROWS - 1));
      w.value = pick_value();
    end else if (sel < 72) begin
      w.func = FN_RD_VAL;
      w.position = POS_W'(blk_pos());
    end else if (sel < 80) begin
      w.func = FN_WR_VAL;
      w.position = POS_W'(blk_pos());
      w.value = pick_value();
    end else if (sel < 84) begin
      w.func = FN_WR_COL;
      w.position = POS_W'(blk_pos());
    end else if (sel < 89) begin
      case ($urandom_range(0, 2))
        0: w.func = FN_WR_COL;
        1: w.func = FN_WR_VAL;
        default: w.func = FN_RD_VAL;
      endcase
      w.position = POS_W'($urandom_range(NNZ, POS_SPAN - 1));
    end else if (sel < 93) begin
      w.func = FN_WR_ROW;
      w.row = ROW_W'($urandom_range(ROWS + 1, ROW_SPAN - 1));
    end else if (sel < 96) begin
      w.func = FN_ACC;
      w.row = ROW_W'($urandom_range(ROWS, ROW_SPAN - 1));
    end else begin
      w.func = FUNC_W'($urandom_range(FN_RD_VAL + 1, FN_BAD));
    end
    // fall back to a plain value write when the word would read unwritten entries
    if (!word_is_safe(w)) begin
      w.func = FN_WR_VAL;
      w.position = POS_W'(blk_pos());
    end
    return w;
  endfunction

  task automatic test_random_traffic();
    int unsigned ops;
    while (n_sent < ITEM_TARGET) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      build_block($urandom_range(1, 8));
      ops = $urandom_range(20, 60);
      if (n_sent + ops > ITEM_TARGET) ops = (n_sent < ITEM_TARGET) ? ITEM_TARGET - n_sent : 0;
      repeat (ops) send_word(traffic_word());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rst_ni      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_store_and_saturate();
    test_row_bounds();
    test_range_errors();
    test_stall_pressure();
    test_random_traffic();

    drain();
    repeat (40) @(posedge clk_i);

    $display("summary: %0d words sent (%0d ignored), %0d results checked",
             n_sent, n_ignored, n_checked);
    $display("summary: %0d accumulate hits (%0d clamped), %0d misses, %0d range errors",
             n_hits, n_saturated, n_misses, n_range);
    if (n_errors == 0) begin
      $display("csr_scatter_add_tb: clean");
    end else begin
      $display("csr_scatter_add_tb: errors");
    end
    $finish;
  end

endmodule

// ===== csr_scatter_add.f =====
hdl/csa_pkg.sv
hdl/csa_if.sv
hdl/csa_ram.sv
hdl/csa_ctrl.sv
hdl/csr_scatter_add.sv
hdl/csa_checker.sv
test/csr_scatter_add_tb.sv
